[design/tef_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tef_pkg
// Shared types and character codes for the calendar text escape and fold unit.
// ----------------------------------------------------------------------------
package tef_pkg;

  localparam int PosW             = 7;
  localparam int FoldPeriodDefault = 77;
  localparam int RunDepth         = 4;
  localparam int RunIdxW          = 2;

  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChSemicolon = 8'h3b;
  localparam logic [7:0] ChComma     = 8'h2c;
  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChLetterN   = 8'h6e;
  localparam logic [7:0] ChSpace     = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [RunDepth-1:0][7:0] bytes;
    logic [RunIdxW-1:0]       last_idx;
  } run_t;

endpackage
`default_nettype wire

[design/ical_text_escape_fold_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ical_text_escape_fold_unit
// Escapes calendar text bytes and folds the output stream into lines.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid / in_stall | in_data  : in_byte, start_of_text
//  out     | out_valid/out_stall | out_data : out_byte, last_of_run
//
//  A request gives 1 to 4 output bytes, one per cycle while out_stall is low.
//  An accepted request passes through the request register, then the result
//  register, before its first byte appears. The next request is built while
//  the previous run drains.
//  Reset clears the position counter and both valid flags.
//  out_stall holds the current byte; in_stall rises once the request
//  register is full and the result register cannot take a new run.
// ----------------------------------------------------------------------------
module ical_text_escape_fold_unit
  import tef_pkg::*;
#(
  parameter int FOLD_PERIOD = FoldPeriodDefault
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic run_free;
  logic run_load;
  run_t run_next;

  tef_fold #(
    .FOLD_PERIOD(FOLD_PERIOD)
  ) u_fold (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .run_free (run_free),
    .run_load (run_load),
    .run_next (run_next)
  );

  tef_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .run_load  (run_load),
    .run_next  (run_next),
    .run_free  (run_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[design/tef_fold.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tef_fold
// Request register, output position counter and escape/fold run builder.
// ----------------------------------------------------------------------------
module tef_fold
  import tef_pkg::*;
#(
  parameter int FOLD_PERIOD = FoldPeriodDefault
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire logic     run_free,
  output logic          run_load,
  output run_t          run_next
);

  localparam logic [PosW-1:0] FoldSlot = PosW'(FOLD_PERIOD - 2);
  localparam logic [PosW:0]   Period   = (PosW + 1)'(FOLD_PERIOD);

  in_item_t        req;
  logic            req_full;
  logic [PosW-1:0] position;
  logic [PosW-1:0] position_next;

  function automatic logic [PosW-1:0] adv(input logic [PosW-1:0] p);
    logic [PosW:0] s;
    s = {1'b0, p} + (PosW + 1)'(1);
    return (s >= Period) ? '0 : s[PosW-1:0];
  endfunction

  assign run_load = req_full && run_free;
  assign in_stall = req_full && !run_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
      position <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        req_full <= 1'b1;
      end else if (run_load) begin
        req_full <= 1'b0;
      end
      if (run_load) begin
        position <= position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req <= in_data;
    end
  end

  always_comb begin
    logic [PosW-1:0] p;
    logic [7:0]      d0;
    logic [7:0]      d1;
    logic            two;
    logic [2:0]      n;
    p   = req.start_of_text ? '0 : position;
    two = 1'b1;
    d1  = req.in_byte;
    d0  = ChBackslash;
    unique case (req.in_byte)
      ChBackslash, ChSemicolon, ChComma: d1 = req.in_byte;
      ChNewline:                         d1 = ChLetterN;
      default: begin
        two = 1'b0;
        d0  = req.in_byte;
      end
    endcase
    n = '0;
    run_next.bytes = '0;
    if (p == FoldSlot) begin
      run_next.bytes[n[RunIdxW-1:0]] = ChNewline;
      n = n + 3'd1;
      run_next.bytes[n[RunIdxW-1:0]] = ChSpace;
      n = n + 3'd1;
      p = adv(adv(p));
    end
    run_next.bytes[n[RunIdxW-1:0]] = d0;
    n = n + 3'd1;
    p = adv(p);
    if (two) begin
      if (p == FoldSlot) begin
        run_next.bytes[n[RunIdxW-1:0]] = ChNewline;
        n = n + 3'd1;
        run_next.bytes[n[RunIdxW-1:0]] = ChSpace;
        n = n + 3'd1;
        p = adv(adv(p));
      end
      run_next.bytes[n[RunIdxW-1:0]] = d1;
      n = n + 3'd1;
      p = adv(p);
    end
    run_next.last_idx = RunIdxW'(n - 3'd1);
    position_next     = p;
  end

endmodule
`default_nettype wire

[design/tef_serial.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tef_serial
// Result register: holds one run and sends it one byte per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module tef_serial
  import tef_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  run_load,
  input  wire run_t  run_next,
  output logic       run_free,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_item_t  out_data
);

  run_t               run;
  logic               run_valid;
  logic [RunIdxW-1:0] idx;
  logic               take;
  logic               at_last;

  assign at_last  = (idx == run.last_idx);
  assign take     = run_valid && !out_stall;
  assign run_free = !run_valid || (take && at_last);

  assign out_valid            = run_valid;
  assign out_data.out_byte    = run.bytes[idx];
  assign out_data.last_of_run = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      idx       <= '0;
    end else if (run_load) begin
      run_valid <= 1'b1;
      idx       <= '0;
    end else if (take) begin
      if (at_last) begin
        run_valid <= 1'b0;
      end else begin
        idx <= idx + RunIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_load) begin
      run <= run_next;
    end
  end

endmodule
`default_nettype wire
